### src/cvkf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvkf_pkg: shared constants and helpers for the constant-velocity filter
// Holds the register indexes, reset values and the saturation helpers.
// ----------------------------------------------------------------------------
package cvkf_pkg;

    localparam int AXES = 3;
    localparam int DT_W = 16;
    localparam int NOISE_W = 24;

    localparam logic [DT_W-1:0]    DT_RESET = 16'd1311;
    localparam logic [NOISE_W-1:0] Q_RESET  = 24'd655;
    localparam logic [NOISE_W-1:0] R_RESET  = 24'd6554;
    localparam logic [31:0]        VAR_RESET = 32'd6554;

    localparam logic [1:0] REG_STEP_TIME     = 2'd0;
    localparam logic [1:0] REG_PROCESS_NOISE = 2'd1;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

    // Saturate a wide signed value to signed 32 bits.
    function automatic logic signed [31:0] sat_s32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Saturate a wide signed value to the variance range [0, 2^31-1].
    function automatic logic signed [31:0] sat_var(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v[65])
            r = 32'sd0;
        else
            r = v[31:0];
        return r;
    endfunction

    // Q16 product rounding: floor((p + 2^15) / 2^16), sign extended to 66 bits.
    function automatic logic signed [65:0] rnd_q16(input logic signed [63:0] p);
        logic signed [63:0] y;
        y = p + 64'sd32768;
        return {{18{y[63]}}, y[63:16]};
    endfunction

    function automatic logic signed [65:0] sx32(input logic signed [31:0] v);
        return {{34{v[31]}}, v};
    endfunction

endpackage

### src/cvkf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvkf_div: bit-serial signed divider with rounding to nearest
// Divides a signed 64-bit numerator by an unsigned 32-bit divisor, ties away
// from zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cvkf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic [31:0]        den,
    output logic               done,
    output logic signed [63:0] quot
);

    logic [63:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        neg_reg;
    logic        done_reg;
    logic signed [63:0] quot_reg;
    logic [63:0] mag;
    logic [32:0] rem_sh;

    always_comb
    begin
        mag = num[63] ? 64'(-num) : 64'(num);
        rem_sh = {rem_reg[31:0], num_reg[63]};
        if (rem_sh >= {1'b0, den_reg})
        begin
            rem_next = rem_sh - {1'b0, den_reg};
            num_next = {num_reg[62:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh;
            num_next = {num_reg[62:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 7'd64)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= mag + {33'd0, den[31:1]};
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[63];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd64)
                quot_reg <= neg_reg ? -$signed(num_reg) : $signed(num_reg);
            else
            begin
                num_reg <= num_next;
                rem_reg <= rem_next;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### src/const_velocity_kalman_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// const_velocity_kalman_filter: 3-D constant-velocity Kalman filter
// Predict and correct per axis in Q16.16 with one shared multiplier and a
// bit-serial divider.
//
//   Channel  Signals                                   Direction
//   input    in_valid, in_ready, meas_x/y/z            into block
//   output   out_valid, out_ready, est_*, var_*        out of block
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data into block
//
// Each transaction works its three axes in turn, each with four predict
// multiplies and five correction divides. An axis whose innovation variance
// is zero skips its divides.
// The result stays on the outputs until its transaction completes; the input
// is not ready while an item is at work or a result is waiting.
// Reset restores the state, configuration and estimates to their defaults at once.
// ----------------------------------------------------------------------------
module const_velocity_kalman_filter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] meas_x,
    input  logic signed [31:0] meas_y,
    input  logic signed [31:0] meas_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] est_pos_x,
    output logic signed [31:0] est_pos_y,
    output logic signed [31:0] est_pos_z,
    output logic signed [31:0] est_vel_x,
    output logic signed [31:0] est_vel_y,
    output logic signed [31:0] est_vel_z,
    output logic [30:0]        var_pos_x,
    output logic [30:0]        var_pos_y,
    output logic [30:0]        var_pos_z,
    output logic [30:0]        var_vel_x,
    output logic [30:0]        var_vel_y,
    output logic [30:0]        var_vel_z
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_LOAD = 8'b0000_0010,
        ST_MUL  = 8'b0000_0100,
        ST_ACC  = 8'b0000_1000,
        ST_CHK  = 8'b0001_0000,
        ST_DIVW = 8'b0010_0000,
        ST_APPLY = 8'b0100_0000,
        ST_NEXT = 8'b1000_0000
    } state_t;

    state_t state_reg;
    logic [1:0] axis_reg;
    logic [3:0] step_reg;
    logic out_valid_reg;

    logic [15:0] dt_reg;
    logic [23:0] q_reg;
    logic [23:0] r_reg;

    logic signed [31:0] est_pos_reg [cvkf_pkg::AXES];
    logic signed [31:0] est_vel_reg [cvkf_pkg::AXES];
    logic signed [31:0] cov_pp_reg  [cvkf_pkg::AXES];
    logic signed [31:0] cov_pv_reg  [cvkf_pkg::AXES];
    logic signed [31:0] cov_vv_reg  [cvkf_pkg::AXES];
    logic signed [31:0] meas_reg    [cvkf_pkg::AXES];

    logic signed [31:0] pos_reg, vel_reg, pp_reg, pv_reg, vv_reg, z_reg, e_reg;
    logic signed [33:0] m00_reg;
    logic signed [32:0] m01_reg;
    logic [31:0] s_reg;
    logic signed [63:0] prod_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_full;
    logic signed [65:0] rnd;
    logic [31:0] s_calc;
    logic div_start, div_done;
    logic signed [63:0] div_q;
    logic signed [32:0] dt_ext;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    assign dt_ext = {17'd0, dt_reg};
    assign rnd = cvkf_pkg::rnd_q16(prod_reg);
    assign s_calc = pp_reg + {8'd0, r_reg};
    assign div_start = (state_reg == ST_ACC) && (step_reg >= 4'd4);

    always_comb
    begin
        case (step_reg)
            4'd0:    begin mul_a = 33'(vel_reg); mul_b = dt_ext; end
            4'd1:    begin mul_a = 33'(pv_reg);  mul_b = dt_ext; end
            4'd2:    begin mul_a = 33'(vv_reg);  mul_b = dt_ext; end
            4'd3:    begin mul_a = m01_reg;      mul_b = dt_ext; end
            4'd4:    begin mul_a = 33'(pp_reg);  mul_b = 33'(e_reg); end
            4'd5:    begin mul_a = 33'(pv_reg);  mul_b = 33'(e_reg); end
            4'd6:    begin mul_a = 33'(pp_reg);  mul_b = 33'(pp_reg); end
            4'd7:    begin mul_a = 33'(pp_reg);  mul_b = 33'(pv_reg); end
            4'd8:    begin mul_a = 33'(pv_reg);  mul_b = 33'(pv_reg); end
            default: begin mul_a = '0;           mul_b = '0; end
        endcase
        mul_full = mul_a * mul_b;
    end

    cvkf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (s_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            dt_reg        <= cvkf_pkg::DT_RESET;
            q_reg         <= cvkf_pkg::Q_RESET;
            r_reg         <= cvkf_pkg::R_RESET;
            for (int i = 0; i < cvkf_pkg::AXES; i++)
            begin
                est_pos_reg[i] <= '0;
                est_vel_reg[i] <= '0;
                cov_pp_reg[i]  <= cvkf_pkg::VAR_RESET;
                cov_pv_reg[i]  <= '0;
                cov_vv_reg[i]  <= cvkf_pkg::VAR_RESET;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cvkf_pkg::REG_STEP_TIME:     dt_reg <= cfg_data[15:0];
                    cvkf_pkg::REG_PROCESS_NOISE: q_reg  <= cfg_data;
                    cvkf_pkg::REG_MEASURE_NOISE: r_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        axis_reg  <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                    state_reg <= ST_ACC;
                ST_ACC:
                begin
                    if (step_reg == 4'd3)
                        state_reg <= ST_CHK;
                    else if (step_reg >= 4'd4)
                        state_reg <= ST_DIVW;
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_CHK:
                begin
                    if (s_calc == 32'd0)
                    begin
                        est_pos_reg[axis_reg] <= pos_reg;
                        est_vel_reg[axis_reg] <= vel_reg;
                        cov_pp_reg[axis_reg]  <= pp_reg;
                        cov_pv_reg[axis_reg]  <= pv_reg;
                        cov_vv_reg[axis_reg]  <= vv_reg;
                        state_reg <= ST_NEXT;
                    end
                    else
                    begin
                        step_reg  <= 4'd4;
                        state_reg <= ST_MUL;
                    end
                end
                ST_DIVW:
                begin
                    if (div_done)
                        state_reg <= ST_APPLY;
                end
                ST_APPLY:
                begin
                    case (step_reg)
                        4'd4: est_pos_reg[axis_reg] <=
                                  cvkf_pkg::sat_s32(cvkf_pkg::sx32(pos_reg) + 66'(div_q));
                        4'd5: est_vel_reg[axis_reg] <=
                                  cvkf_pkg::sat_s32(cvkf_pkg::sx32(vel_reg) + 66'(div_q));
                        4'd6: cov_pp_reg[axis_reg] <=
                                  cvkf_pkg::sat_var(cvkf_pkg::sx32(pp_reg) - 66'(div_q));
                        4'd7: cov_pv_reg[axis_reg] <=
                                  cvkf_pkg::sat_s32(cvkf_pkg::sx32(pv_reg) - 66'(div_q));
                        4'd8: cov_vv_reg[axis_reg] <=
                                  cvkf_pkg::sat_var(cvkf_pkg::sx32(vv_reg) - 66'(div_q));
                        default: ;
                    endcase
                    if (step_reg == 4'd8)
                        state_reg <= ST_NEXT;
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_NEXT:
                begin
                    if (axis_reg == 2'd2)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_LOAD;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            meas_reg[0] <= meas_x;
            meas_reg[1] <= meas_y;
            meas_reg[2] <= meas_z;
        end
        case (state_reg)
            ST_LOAD:
            begin
                pos_reg <= est_pos_reg[axis_reg];
                vel_reg <= est_vel_reg[axis_reg];
                pp_reg  <= cov_pp_reg[axis_reg];
                pv_reg  <= cov_pv_reg[axis_reg];
                vv_reg  <= cov_vv_reg[axis_reg];
                z_reg   <= meas_reg[axis_reg];
            end
            ST_MUL:
                prod_reg <= mul_full[63:0];
            ST_ACC:
            begin
                case (step_reg)
                    4'd0: pos_reg <= cvkf_pkg::sat_s32(cvkf_pkg::sx32(pos_reg) + rnd);
                    4'd1: m00_reg <= 34'(cvkf_pkg::sx32(pp_reg) + rnd);
                    4'd2: m01_reg <= 33'(cvkf_pkg::sx32(pv_reg) + rnd);
                    4'd3:
                    begin
                        pp_reg <= cvkf_pkg::sat_var(66'(m00_reg) + rnd + {42'd0, q_reg});
                        pv_reg <= cvkf_pkg::sat_s32(66'(m01_reg));
                        vv_reg <= cvkf_pkg::sat_var(cvkf_pkg::sx32(vv_reg) + {42'd0, q_reg});
                    end
                    default: ;
                endcase
            end
            ST_CHK:
            begin
                s_reg <= s_calc;
                e_reg <= cvkf_pkg::sat_s32(cvkf_pkg::sx32(z_reg) - cvkf_pkg::sx32(pos_reg));
            end
            default: ;
        endcase
    end

    assign est_pos_x = est_pos_reg[0];
    assign est_pos_y = est_pos_reg[1];
    assign est_pos_z = est_pos_reg[2];
    assign est_vel_x = est_vel_reg[0];
    assign est_vel_y = est_vel_reg[1];
    assign est_vel_z = est_vel_reg[2];
    assign var_pos_x = cov_pp_reg[0][30:0];
    assign var_pos_y = cov_pp_reg[1][30:0];
    assign var_pos_z = cov_pp_reg[2][30:0];
    assign var_vel_x = cov_vv_reg[0][30:0];
    assign var_vel_y = cov_vv_reg[1][30:0];
    assign var_vel_z = cov_vv_reg[2][30:0];

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVW)
        else $error("Divider finished outside of its wait state.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == ST_LOAD && axis_reg == 2'd0)
        else $error("Accepted transaction did not start the first axis.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !cov_pp_reg[0][31] && !cov_pp_reg[1][31] && !cov_pp_reg[2][31])
        else $error("Position variance left its range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_NEXT)
        else $error("Result raised without finishing the last axis.");

endmodule
